// ----- rtl/core/llfl_pkg.sv -----
// ----------------------------------------------------------------------------
// Linked list with free list: shared definitions
// Default sizing, field widths, command codes and status codes.
// ----------------------------------------------------------------------------
package llfl_pkg;

    localparam int NODE_COUNT_DEF = 16;

    localparam int VALUE_W   = 32;
    localparam int POS_W     = 8;
    localparam int OP_W      = 3;
    localparam int ST_W      = 3;
    localparam int IN_DATA_W = VALUE_W + POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_END   = 3'd4,
        OP_DEL_VAL   = 3'd5,
        OP_SEARCH    = 3'd6
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_FREE   = 3'd1,
        ST_BAD_POS   = 3'd2,
        ST_RANGE     = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

endpackage

// ----- rtl/core/linked_list_with_free_list.sv -----
// ----------------------------------------------------------------------------
// Linked list with free list
// Singly linked list held in node value and link memories, with a free chain.
//
// Usage: one command beat enters on the slave stream (op on tuser, value and
// insert position on tdata) and gives exactly one result beat on the master
// stream (status and found position on tdata).
// The block handles one command at a time: tready is high only while it is
// idle. An error or an unused code goes from decode straight to the result;
// insert at front and delete at front need no walk along the list, and the
// longest command walks over every node and then patches a link. The
// walk follows one link per cycle through the single read port of the link
// memory; inserts at the end or at a position, deletes at the end or by value
// and search walk. tready returns together with the result valid.
// After reset the block runs an initialization pass that chains every node
// into the free list; tready stays low during it.
// The result sits in an output register. When the receiver stalls, the block
// still takes the next command and works on it; it waits at the end of that
// command only if the previous result has not yet been taken.
// ----------------------------------------------------------------------------
module linked_list_with_free_list #(
    parameter int NODE_COUNT = llfl_pkg::NODE_COUNT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Command stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata: item_value [31:0], list_position [39:32]
    input  logic [llfl_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    // tuser: op [2:0]
    input  logic [llfl_pkg::OP_W-1:0]             i_s_axis_tuser,
    // Result stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // tdata: status [2:0], found_position [3 +: clog2(NODE_COUNT+1)], zero fill
    output logic [((llfl_pkg::ST_W + $clog2(NODE_COUNT + 1) + 7) / 8) * 8 - 1:0]
                                                  o_m_axis_tdata
);
    import llfl_pkg::*;

    localparam int AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int IW    = $clog2(NODE_COUNT + 1);
    localparam int KW    = ((IW > POS_W) ? IW : POS_W) + 1;
    localparam int OUT_W = ((ST_W + IW + 7) / 8) * 8;

    // A link equal to the node count marks the end of a chain.
    localparam logic [IW-1:0] NULL_IDX = IW'(NODE_COUNT);
    localparam logic [IW-1:0] WALK_LIM = IW'(NODE_COUNT);
    localparam logic [AW-1:0] INIT_END = AW'(NODE_COUNT - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_TAKEN,
        S_WALK,
        S_PATCH,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_init_cnt;
    t_op                 r_op;
    logic [VALUE_W-1:0]  r_value;
    logic [POS_W-1:0]    r_pos;
    logic [IW-1:0]       r_head;
    logic [IW-1:0]       r_free;
    logic [IW-1:0]       r_node;
    logic [IW-1:0]       r_cur;
    logic [IW-1:0]       r_prev;
    logic [IW-1:0]       r_cnt;
    logic [IW-1:0]       r_pa;
    logic [IW-1:0]       r_pd;
    t_status             r_status;
    logic [IW-1:0]       r_found;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [IW-1:0]       r_out_found;

    logic [IW-1:0]       r_link_mem [NODE_COUNT];
    logic [VALUE_W-1:0]  r_value_mem [NODE_COUNT];
    logic [IW-1:0]       r_link_rd;
    logic [VALUE_W-1:0]  r_val_rd;

    logic [AW-1:0]       c_rd_addr;
    logic                c_link_we;
    logic [AW-1:0]       c_link_wa;
    logic [IW-1:0]       c_link_wd;
    logic                c_val_we;

    logic                c_nxt_ok;
    logic                c_pos_more;
    logic                c_first;
    logic                c_match;
    logic                c_adv;

    // Walk decisions, taken on the node whose read data is now registered.
    assign c_nxt_ok   = (r_link_rd < NULL_IDX) && (r_cnt < WALK_LIM);
    assign c_pos_more = (KW'(r_cnt) + KW'(1)) < KW'(r_pos);
    assign c_first    = (r_cnt == IW'(1));
    assign c_match    = (r_val_rd == r_value);

    always_comb begin
        case (r_op)
            OP_INS_END:  c_adv = c_nxt_ok;
            OP_INS_POS:  c_adv = c_nxt_ok && c_pos_more;
            OP_DEL_END:  c_adv = c_nxt_ok;
            OP_DEL_VAL:  c_adv = !c_match && c_nxt_ok;
            OP_SEARCH:   c_adv = !c_match && c_nxt_ok;
            default:     c_adv = 1'b0;
        endcase
    end

    // Memory port control.
    always_comb begin
        c_rd_addr = r_head[AW-1:0];
        c_link_we = 1'b0;
        c_link_wa = r_cur[AW-1:0];
        c_link_wd = r_free;
        c_val_we  = 1'b0;
        case (r_state)
            S_INIT: begin
                c_link_we = 1'b1;
                c_link_wa = r_init_cnt;
                c_link_wd = IW'(r_init_cnt) + IW'(1);
            end
            S_DECODE: begin
                if (r_op == OP_INS_FRONT || r_op == OP_INS_END || r_op == OP_INS_POS) begin
                    c_rd_addr = r_free[AW-1:0];
                end
            end
            S_TAKEN: begin
                c_val_we  = 1'b1;
                c_link_wa = r_free[AW-1:0];
                if (r_op == OP_INS_END) begin
                    c_link_we = 1'b1;
                    c_link_wd = NULL_IDX;
                end else if (r_op == OP_INS_FRONT || r_pos == POS_W'(1)) begin
                    c_link_we = 1'b1;
                    c_link_wd = r_head;
                end
            end
            S_WALK: begin
                c_rd_addr = r_link_rd[AW-1:0];
                if (!c_adv) begin
                    case (r_op)
                        OP_INS_END: begin
                            c_link_we = 1'b1;
                            c_link_wd = r_node;
                        end
                        OP_INS_POS: begin
                            c_link_we = 1'b1;
                            c_link_wa = r_node[AW-1:0];
                            c_link_wd = r_link_rd;
                        end
                        OP_DEL_FRONT, OP_DEL_END: begin
                            c_link_we = 1'b1;
                        end
                        OP_DEL_VAL: begin
                            if (c_match) begin
                                c_link_we = 1'b1;
                                // An inner match unlinks the node from its predecessor.
                                if (!c_first) begin
                                    c_link_wa = r_prev[AW-1:0];
                                    c_link_wd = r_link_rd;
                                end
                            end
                        end
                        default: begin
                            c_link_we = 1'b0;
                        end
                    endcase
                end
            end
            S_PATCH: begin
                c_link_we = 1'b1;
                c_link_wa = r_pa[AW-1:0];
                c_link_wd = r_pd;
            end
            default: begin
                c_link_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_link_we) begin
            r_link_mem[c_link_wa] <= c_link_wd;
        end
        r_link_rd <= r_link_mem[c_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (c_val_we) begin
            r_value_mem[r_free[AW-1:0]] <= r_value;
        end
        r_val_rd <= r_value_mem[c_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_cnt  <= '0;
            r_head      <= NULL_IDX;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A result loaded in the done state takes the place of one leaving.
            if (r_out_valid && i_m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_init_cnt <= r_init_cnt + AW'(1);
                    if (r_init_cnt == INIT_END) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op    <= t_op'(i_s_axis_tuser);
                        r_value <= i_s_axis_tdata[VALUE_W-1:0];
                        r_pos   <= i_s_axis_tdata[VALUE_W +: POS_W];
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_found  <= '0;
                    r_cur    <= r_head;
                    r_cnt    <= IW'(1);
                    case (r_op)
                        OP_INS_FRONT, OP_INS_END: begin
                            if (r_free >= NULL_IDX) begin
                                r_status <= ST_NO_FREE;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_TAKEN;
                            end
                        end
                        OP_INS_POS: begin
                            if (r_pos == '0) begin
                                r_status <= ST_BAD_POS;
                                r_state  <= S_DONE;
                            end else if (r_free >= NULL_IDX) begin
                                r_status <= ST_NO_FREE;
                                r_state  <= S_DONE;
                            end else if (r_pos != POS_W'(1) && r_head >= NULL_IDX) begin
                                // The node would be taken and given back: no net change.
                                r_status <= ST_RANGE;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_TAKEN;
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_END, OP_DEL_VAL: begin
                            if (r_head >= NULL_IDX) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_WALK;
                            end
                        end
                        OP_SEARCH: begin
                            if (r_head >= NULL_IDX) begin
                                r_status <= ST_NOT_FOUND;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_WALK;
                            end
                        end
                        default: begin
                            r_status <= ST_OK;
                            r_state  <= S_DONE;
                        end
                    endcase
                end
                S_TAKEN: begin
                    // The link read of the free head is now available.
                    r_node <= r_free;
                    r_free <= r_link_rd;
                    if (r_op == OP_INS_END && r_head >= NULL_IDX) begin
                        r_head  <= r_free;
                        r_state <= S_DONE;
                    end else if (r_op == OP_INS_END ||
                                 (r_op == OP_INS_POS && r_pos != POS_W'(1))) begin
                        r_state <= S_WALK;
                    end else begin
                        r_head  <= r_free;
                        r_state <= S_DONE;
                    end
                end
                S_WALK: begin
                    if (c_adv) begin
                        r_prev <= r_cur;
                        r_cur  <= r_link_rd;
                        r_cnt  <= r_cnt + IW'(1);
                    end else begin
                        case (r_op)
                            OP_INS_POS: begin
                                r_pa    <= r_cur;
                                r_pd    <= r_node;
                                r_state <= S_PATCH;
                            end
                            OP_DEL_FRONT: begin
                                r_free  <= r_cur;
                                r_head  <= r_link_rd;
                                r_state <= S_DONE;
                            end
                            OP_DEL_END: begin
                                r_free <= r_cur;
                                if (c_first) begin
                                    r_head  <= NULL_IDX;
                                    r_state <= S_DONE;
                                end else begin
                                    r_pa    <= r_prev;
                                    r_pd    <= NULL_IDX;
                                    r_state <= S_PATCH;
                                end
                            end
                            OP_DEL_VAL: begin
                                if (c_match) begin
                                    r_free <= r_cur;
                                    if (c_first) begin
                                        r_head  <= r_link_rd;
                                        r_state <= S_DONE;
                                    end else begin
                                        r_pa    <= r_cur;
                                        r_pd    <= r_free;
                                        r_state <= S_PATCH;
                                    end
                                end else begin
                                    r_status <= ST_NOT_FOUND;
                                    r_state  <= S_DONE;
                                end
                            end
                            OP_SEARCH: begin
                                if (c_match) begin
                                    r_found <= r_cnt;
                                end else begin
                                    r_status <= ST_NOT_FOUND;
                                end
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_PATCH: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_found  <= r_found;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_found, r_out_status});

    // The block works on one command at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("command accepted while a command is in progress");

    // The list and the free chain never start at the same node.
    a_chains_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_head < NULL_IDX) && (r_head == r_free)))
        else $error("list head and free head point to the same node");

    // A walk only ever visits real nodes.
    a_walk_on_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_cur < NULL_IDX))
        else $error("list walk reached a null link");

endmodule
